// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and helpers of the JSON string unescaper
// Status codes, the decoded-operation record passed from the front end to
// the back end, and the UTF-8 byte encoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int CP_W          = 21;
  localparam int QUEUE_DEPTH_D = 4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_ESC = 3'd1;
  localparam logic [2:0] ST_BAD_HEX = 3'd2;
  localparam logic [2:0] ST_BAD_SUR = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  typedef struct packed {
    logic            done;
    logic [2:0]      status;
    logic [1:0]      len_m1;
    logic [CP_W-1:0] cp;
  } op_t;

  // byte idx of the encoding of cp; length one passes cp[7:0] unchanged
  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                           input logic [1:0] len_m1,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = cp[7:0];
    case (len_m1)
      2'd0: b = cp[7:0];
      2'd1: begin
        if (idx == 2'd0) b = {3'b110, cp[10:6]};
        else b = {2'b10, cp[5:0]};
      end
      2'd2: begin
        case (idx)
          2'd0: b = {4'b1110, cp[15:12]};
          2'd1: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/json_string_unescape_utf8_top.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top: JSON string unescaper with UTF-8 output
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_ready    data_byte, close
//   output   out        out_valid / out_ready  out_byte, has_byte, done_res,
//                                              status
//
// One input transaction per cycle while the operation queue has room.
// A result passes through a queue slot and then the output register on its
// way out; multi-byte UTF-8 sequences leave one byte per cycle while the
// output is not stalled, so the output byte rate bounds throughput.
// Synchronous reset clears parser state, queue and output valid. A stalled
// output fills the queue, then drops in_ready.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       close,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       done_res,
  output logic [2:0] status
);

  logic q_full, push, pop, head_valid;
  op_t  push_op, head_op;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .close     (close),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_op    (head_op),
    .head_valid (head_valid)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_op    (head_op),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .done_res   (done_res),
    .status     (status)
  );

endmodule

// ===== rtl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front: escape parser
// Accepts one raw byte or close per cycle unless q_full, tracks the escape
// phase, hex digits and a pending high surrogate; pushes one op per result.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       close,
  input  logic       q_full,
  output logic       push,
  output op_t        push_op
);

  localparam logic [2:0] PH_PLAIN   = 3'd0;
  localparam logic [2:0] PH_ESC     = 3'd1;
  localparam logic [2:0] PH_HEX     = 3'd2;
  localparam logic [2:0] PH_WAIT_BS = 3'd3;
  localparam logic [2:0] PH_WAIT_U  = 3'd4;
  localparam logic [2:0] PH_LOW_HEX = 3'd5;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  logic [2:0]  phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_unit, code_unit_next;
  logic [9:0]  high_sur, high_sur_next;
  logic [2:0]  err, err_next;

  logic        accept;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cu_new;
  logic [CP_W-1:0] pair_cp;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hex_ok  = 1'b0;
    hex_val = data_byte[3:0];
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      hex_ok = 1'b1;
    end else if ((data_byte >= 8'h41 && data_byte <= 8'h46) ||
                 (data_byte >= 8'h61 && data_byte <= 8'h66)) begin
      hex_ok  = 1'b1;
      hex_val = data_byte[3:0] + 4'd9;
    end
  end

  assign cu_new  = {code_unit[11:0], hex_val};
  assign pair_cp = {1'b0, high_sur, cu_new[9:0]} + 21'h10000;

  always_comb begin
    phase_next     = phase;
    hex_count_next = hex_count;
    code_unit_next = code_unit;
    high_sur_next  = high_sur;
    err_next       = err;
    push           = 1'b0;
    push_op        = '0;
    if (accept) begin
      if (close) begin
        push           = 1'b1;
        push_op.done   = 1'b1;
        push_op.status = err;
        if (err == ST_OK) begin
          if (phase == PH_WAIT_BS) push_op.status = ST_BAD_SUR;
          else if (phase != PH_PLAIN) push_op.status = ST_TRUNC;
        end
        phase_next     = PH_PLAIN;
        hex_count_next = '0;
        code_unit_next = '0;
        high_sur_next  = '0;
        err_next       = ST_OK;
      end else if (err == ST_OK) begin
        case (phase)
          PH_ESC: begin
            phase_next = PH_PLAIN;
            push       = 1'b1;
            case (data_byte)
              CH_QUOTE, CH_BSLASH, CH_SLASH: push_op.cp = {13'd0, data_byte};
              CH_B: push_op.cp = 21'd8;
              CH_F: push_op.cp = 21'd12;
              CH_N: push_op.cp = 21'd10;
              CH_R: push_op.cp = 21'd13;
              CH_T: push_op.cp = 21'd9;
              CH_U: begin
                push           = 1'b0;
                phase_next     = PH_HEX;
                hex_count_next = '0;
                code_unit_next = '0;
              end
              default: begin
                push     = 1'b0;
                err_next = ST_BAD_ESC;
              end
            endcase
          end
          PH_WAIT_BS: begin
            if (data_byte == CH_BSLASH) phase_next = PH_WAIT_U;
            else err_next = ST_BAD_SUR;
          end
          PH_WAIT_U: begin
            if (data_byte == CH_U) begin
              phase_next     = PH_LOW_HEX;
              hex_count_next = '0;
              code_unit_next = '0;
            end else begin
              err_next = ST_BAD_SUR;
            end
          end
          PH_HEX, PH_LOW_HEX: begin
            if (!hex_ok) begin
              err_next = ST_BAD_HEX;
            end else if (hex_count != 2'd3) begin
              hex_count_next = hex_count + 2'd1;
              code_unit_next = cu_new;
            end else begin
              hex_count_next = '0;
              code_unit_next = '0;
              if (phase == PH_HEX) begin
                if (cu_new >= 16'hD800 && cu_new <= 16'hDBFF) begin
                  high_sur_next = cu_new[9:0];
                  phase_next    = PH_WAIT_BS;
                end else if (cu_new >= 16'hDC00 && cu_new <= 16'hDFFF) begin
                  err_next = ST_BAD_SUR;
                end else begin
                  phase_next = PH_PLAIN;
                  push       = 1'b1;
                  push_op.cp = {5'd0, cu_new};
                  if (cu_new <= 16'h007F) push_op.len_m1 = 2'd0;
                  else if (cu_new <= 16'h07FF) push_op.len_m1 = 2'd1;
                  else push_op.len_m1 = 2'd2;
                end
              end else begin
                if (cu_new < 16'hDC00 || cu_new > 16'hDFFF) begin
                  err_next = ST_BAD_SUR;
                end else begin
                  phase_next     = PH_PLAIN;
                  high_sur_next  = '0;
                  push           = 1'b1;
                  push_op.cp     = pair_cp;
                  push_op.len_m1 = 2'd3;
                end
              end
            end
          end
          default: begin
            phase_next = PH_PLAIN;
            if (data_byte == CH_BSLASH) begin
              phase_next = PH_ESC;
            end else begin
              push       = 1'b1;
              push_op.cp = {13'd0, data_byte};
            end
          end
        endcase
        if (err_next != ST_OK) begin
          phase_next     = PH_PLAIN;
          hex_count_next = '0;
          code_unit_next = '0;
          high_sur_next  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_PLAIN;
      hex_count <= '0;
      code_unit <= '0;
      high_sur  <= '0;
      err       <= ST_OK;
    end else begin
      phase     <= phase_next;
      hex_count <= hex_count_next;
      code_unit <= code_unit_next;
      high_sur  <= high_sur_next;
      err       <= err_next;
    end
  end

endmodule

// ===== rtl/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue: operation queue
// Short first-in first-out buffer of decoded operations between the parser
// and the byte emitter; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_D
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output op_t  head_op,
  output logic head_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CFULL = CW'(DEPTH);

  op_t           slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = (count == CFULL);
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back: byte emitter
// Expands each queued operation into its UTF-8 bytes or the final status
// result, one byte per cycle unless output stalls, into the output register.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  op_t        head_op,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       done_res,
  output logic [2:0] status
);

  logic [1:0] idx;
  logic       load;

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && (head_op.done || idx == head_op.len_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (pop) idx <= '0;
      else if (load) idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head_op.done ? 8'd0 : utf8_byte(head_op.cp, head_op.len_m1, idx);
      has_byte <= !head_op.done;
      done_res <= head_op.done;
      status   <= head_op.done ? head_op.status : ST_OK;
    end
  end

endmodule

// ===== rtl/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker: port checks of the JSON string unescaper
// Watches the top-level ports for result encoding, reset and stall rules.
// ----------------------------------------------------------------------------
module jsu_checker
  import jsu_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       has_byte,
  input logic       done_res,
  input logic [2:0] status
);

  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_byte |-> !done_res && status == ST_OK)
    else $error("decoded byte transaction carries status or done");

  a_final_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !has_byte && out_byte == 8'd0 && status <= ST_TRUNC)
    else $error("final transaction malformed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status))
    else $error("stalled output transaction changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction withdrawn before acceptance");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .has_byte  (has_byte),
  .done_res  (done_res),
  .status    (status)
);

// ===== bench/json_unescape_checker.sv =====
// ----------------------------------------------------------------------------
// json_unescape_checker: decoded byte predictor and result comparator
// Watches both channels of the JSON string unescaper. Every accepted input
// transaction advances a private copy of the escape parser and queues the
// UTF-8 bytes and close status it must produce; every accepted output
// transaction is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module json_unescape_checker
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       close,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       has_byte,
  input  logic       done_res,
  input  logic [2:0] status,
  output int         err_count,
  output int         pending
);

  typedef enum logic [2:0] {
    PH_PLAIN,
    PH_BACKSLASH,
    PH_HEX,
    PH_WAIT_BS,
    PH_WAIT_U,
    PH_LOW_HEX
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] value;
    logic       has;
    logic       fin;
    logic [2:0] st;
  } utf8_result_t;

  parse_phase_e phase;
  logic [1:0]   hex_count;
  logic [15:0]  code_unit;
  logic [9:0]   high_half;
  logic [2:0]   latched_status;
  utf8_result_t expected_utf8[$];

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c <= "9") return c[3:0];
    return c[3:0] + 4'd9;
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    expected_utf8.push_back('{value: b, has: 1'b1, fin: 1'b0, st: ST_OK});
  endtask

  task automatic queue_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      queue_byte(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      queue_byte(8'hC0 | cp[10:6]);
      queue_byte(8'h80 | cp[5:0]);
    end else if (cp <= 21'hFFFF) begin
      queue_byte(8'hE0 | cp[15:12]);
      queue_byte(8'h80 | cp[11:6]);
      queue_byte(8'h80 | cp[5:0]);
    end else begin
      queue_byte(8'hF0 | cp[20:18]);
      queue_byte(8'h80 | cp[17:12]);
      queue_byte(8'h80 | cp[11:6]);
      queue_byte(8'h80 | cp[5:0]);
    end
  endtask

  task automatic reset_parse();
    phase     = PH_PLAIN;
    hex_count = 2'd0;
    code_unit = 16'h0000;
    high_half = 10'h000;
  endtask

  task automatic latch_status(input logic [2:0] code);
    latched_status = code;
    reset_parse();
  endtask

  task automatic unescape_step(input logic [7:0] c, input logic cl);
    logic [2:0]  st;
    logic [20:0] cp;
    if (cl) begin
      st = latched_status;
      if (st == ST_OK && phase == PH_WAIT_BS) st = ST_BAD_SUR;
      else if (st == ST_OK && phase != PH_PLAIN) st = ST_TRUNC;
      expected_utf8.push_back('{value: 8'h00, has: 1'b0, fin: 1'b1, st: st});
      latch_status(ST_OK);
    end else if (latched_status == ST_OK) begin
      case (phase)
        PH_PLAIN: begin
          if (c == "\\") phase = PH_BACKSLASH;
          else queue_byte(c);
        end
        PH_BACKSLASH: begin
          case (c)
            "\"", "\\", "/": begin
              queue_byte(c);
              phase = PH_PLAIN;
            end
            "b": begin
              queue_byte(8'h08);
              phase = PH_PLAIN;
            end
            "f": begin
              queue_byte(8'h0C);
              phase = PH_PLAIN;
            end
            "n": begin
              queue_byte(8'h0A);
              phase = PH_PLAIN;
            end
            "r": begin
              queue_byte(8'h0D);
              phase = PH_PLAIN;
            end
            "t": begin
              queue_byte(8'h09);
              phase = PH_PLAIN;
            end
            "u": begin
              phase     = PH_HEX;
              hex_count = 2'd0;
              code_unit = 16'h0000;
            end
            default: latch_status(ST_BAD_ESC);
          endcase
        end
        PH_WAIT_BS: begin
          if (c == "\\") phase = PH_WAIT_U;
          else latch_status(ST_BAD_SUR);
        end
        PH_WAIT_U: begin
          if (c == "u") begin
            phase     = PH_LOW_HEX;
            hex_count = 2'd0;
            code_unit = 16'h0000;
          end else begin
            latch_status(ST_BAD_SUR);
          end
        end
        default: begin
          if (!is_hex(c)) begin
            latch_status(ST_BAD_HEX);
          end else begin
            code_unit = {code_unit[11:0], hex_nibble(c)};
            if (hex_count != 2'd3) begin
              hex_count = hex_count + 2'd1;
            end else begin
              hex_count = 2'd0;
              if (phase == PH_HEX && code_unit >= 16'hD800 && code_unit <= 16'hDBFF) begin
                high_half = code_unit[9:0];
                code_unit = 16'h0000;
                phase     = PH_WAIT_BS;
              end else if (phase == PH_HEX && code_unit >= 16'hDC00 && code_unit <= 16'hDFFF) begin
                latch_status(ST_BAD_SUR);
              end else if (phase == PH_HEX) begin
                phase = PH_PLAIN;
                queue_code_point({5'd0, code_unit});
                code_unit = 16'h0000;
              end else if (code_unit < 16'hDC00 || code_unit > 16'hDFFF) begin
                latch_status(ST_BAD_SUR);
              end else begin
                cp = 21'h10000 + {high_half, code_unit[9:0]};
                reset_parse();
                queue_code_point(cp);
              end
            end
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin : watch
    utf8_result_t got;
    utf8_result_t want;
    if (rst) begin
      latch_status(ST_OK);
      expected_utf8.delete();
    end else begin
      if (in_valid && in_ready) unescape_step(data_byte, close);
      if (out_valid && out_ready) begin
        got = '{value: out_byte, has: has_byte, fin: done_res, st: status};
        if (expected_utf8.size() == 0) begin
          $error("unexpected result: out_byte %0h has_byte %0b done_res %0b status %0d",
                 out_byte, has_byte, done_res, status);
          err_count++;
        end else begin
          want = expected_utf8.pop_front();
          if (got.value !== want.value) begin
            $error("out_byte: expected %0h, got %0h", want.value, got.value);
            err_count++;
          end
          if (got.has !== want.has) begin
            $error("has_byte: expected %0b, got %0b", want.has, got.has);
            err_count++;
          end
          if (got.fin !== want.fin) begin
            $error("done_res: expected %0b, got %0b", want.fin, got.fin);
            err_count++;
          end
          if (got.st !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, got.st);
            err_count++;
          end
        end
      end
    end
    pending = expected_utf8.size();
  end

endmodule

// ===== bench/tb_json_string_unescape_utf8_top.sv =====
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_top: testbench of the JSON string unescaper
// Feeds string bodies byte by byte, each ended by a close transaction: a
// short directed set, then random strings built from plain bytes, simple
// escapes, \u escapes and surrogate pairs, with a share of broken escapes
// and cut-off strings. Both channels idle in random bursts; a side checker
// predicts the output stream and counts mismatches.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_top;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 180;
  localparam int CALM_TAIL    = 40;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       close     = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       done_res;
  logic [2:0] status;

  int    err_count;
  int    pending;
  int    items_sent   = 0;
  int    stuck_cycles = 0;
  bit    idle_on      = 1'b1;
  string escape_letters = "\"\\/bfnrt";
  string bad_escapes    = "aqxUBN0 '?";
  string non_hex        = "gGzZ/:@~ \\\"";

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  json_string_unescape_utf8_top DUT (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .close,
    .out_valid, .out_ready, .out_byte, .has_byte, .done_res, .status
  );

  json_unescape_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .close,
    .out_valid, .out_ready, .out_byte, .has_byte, .done_res, .status,
    .err_count, .pending
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    close     <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  task automatic close_string();
    push_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  task automatic send_unit(input logic [15:0] u);
    push_byte("\\", 1'b0);
    push_byte("u", 1'b0);
    for (int k = 3; k >= 0; k--) push_byte(hex_char(u[4*k +: 4]), 1'b0);
  endtask

  task automatic send_partial_hex();
    push_byte("\\", 1'b0);
    push_byte("u", 1'b0);
    repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
  endtask

  function automatic logic [9:0] surrogate_offset();
    case ($urandom_range(0, 3))
      0: return 10'h000;
      1: return 10'h3FF;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [15:0] random_unit();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'($urandom_range(1, 16'h7F));
      2: return 16'($urandom_range(16'h80, 16'h7FF));
      3: return 16'($urandom_range(16'h800, 16'hD7FF));
      4: return 16'($urandom_range(16'hE000, 16'hFFFF));
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic random_string();
    int         kind;
    logic [7:0] b;
    logic [15:0] hi;
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: push_byte(8'($urandom_range(0, 255)), 1'b0);
        3, 4: begin
          push_byte("\\", 1'b0);
          push_byte(escape_letters[$urandom_range(0, 7)], 1'b0);
        end
        5, 6, 7: send_unit(random_unit());
        default: begin
          send_unit(16'hD800 + surrogate_offset());
          send_unit(16'hDC00 + surrogate_offset());
        end
      endcase
    end
    if ($urandom_range(0, 2) == 0) begin
      kind = $urandom_range(0, 6);
      hi   = 16'hD800 + surrogate_offset();
      b    = 8'($urandom_range(0, 255));
      case (kind)
        0: begin
          push_byte("\\", 1'b0);
          if ($urandom_range(0, 1)) push_byte(bad_escapes[$urandom_range(0, 9)], 1'b0);
          else push_byte(8'($urandom_range(128, 255)), 1'b0);
        end
        1: begin
          send_partial_hex();
          push_byte(non_hex[$urandom_range(0, non_hex.len() - 1)], 1'b0);
        end
        2: send_unit(16'hDC00 + surrogate_offset());
        3: begin
          send_unit(hi);
          push_byte((b == "\\") ? 8'h5D : b, 1'b0);
        end
        4: begin
          send_unit(hi);
          push_byte("\\", 1'b0);
          push_byte((b == "u") ? 8'h76 : b, 1'b0);
        end
        5: begin
          send_unit(hi);
          send_unit($urandom_range(0, 1) ? random_unit() : 16'hD800 + surrogate_offset());
        end
        default: begin
          case ($urandom_range(0, 4))
            0: push_byte("\\", 1'b0);
            1: send_partial_hex();
            2: send_unit(hi);
            3: begin
              send_unit(hi);
              push_byte("\\", 1'b0);
            end
            default: begin
              send_unit(hi);
              send_partial_hex();
            end
          endcase
        end
      endcase
      if (kind != 6) repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    close_string();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte("\"", 1'b0);
    send_text("\\n\\ud83d\\ude00");
    close_string();
    send_text("\\qA");
    close_string();
    send_text("\\");
    close_string();
    send_text("\\ug");
    close_string();
    send_text("\\udc00");
    close_string();
    send_text("\\ud800x");
    close_string();

    // hold the input until every expected result has drained
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      idle_on = (items_sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      random_string();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_top.sv
rtl/jsu_checker.sv
bench/json_unescape_checker.sv
bench/tb_json_string_unescape_utf8_top.sv
